FILE: hdl/cl_pkg.sv
// Shared types, sound codes and tune tables for the code lock block.
// No dependencies; imported by cl_core and code_lock_with_alarm_tunes.
package cl_pkg;

    localparam logic [7:0] LOCK_CMD = 8'hFF;

    // sound request / speaker mode codes
    localparam logic [2:0] SND_NONE    = 3'd0;
    localparam logic [2:0] SND_LOCK    = 3'd1;
    localparam logic [2:0] SND_UNLOCK  = 3'd2;
    localparam logic [2:0] SND_FAIL    = 3'd3;
    localparam logic [2:0] SND_ALARM   = 3'd4;
    localparam logic [2:0] SND_SUCCESS = 3'd5;

    // register indexes on the config port
    localparam logic [1:0] REG_CODE_ONE   = 2'd0;
    localparam logic [1:0] REG_CODE_TWO   = 2'd1;
    localparam logic [1:0] REG_CODE_THREE = 2'd2;
    localparam logic [1:0] REG_ALARM_CNT  = 2'd3;

    typedef struct packed {
        logic [1:0] link_phase;
        logic [7:0] last_rx;
        logic [7:0] first_try;
        logic [7:0] second_try;
        logic       locked;
        logic [7:0] fail_count;
        logic [2:0] sound_req;
        logic [2:0] spk_mode;
        logic [7:0] led;
    } lock_state_t;

    typedef struct packed {
        logic [7:0] code_one;
        logic [7:0] code_two;
        logic [7:0] code_three;
        logic [7:0] alarm_count;
    } lock_cfg_t;

    // note codes: 0 silent, 1..8 = C4 .. C5
    function automatic logic [3:0] tune_note(input logic [2:0] mode, input logic [3:0] idx);
        logic [3:0] n;
        n = 4'd0;
        case (mode)
            SND_LOCK:    n = 4'd8 - 4'(idx[3:1]);
            SND_UNLOCK:  n = 4'd1 + 4'(idx[3:1]);
            SND_FAIL:    n = idx[3] ? 4'd1 : 4'd8;
            SND_ALARM:   n = idx[2] ? 4'd1 : 4'd5;
            SND_SUCCESS: begin
                case (idx[3:2])
                    2'd0:    n = 4'd1;
                    2'd1:    n = 4'd3;
                    2'd2:    n = 4'd6;
                    default: n = 4'd8;
                endcase
            end
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/cl_core.sv
// Next-state logic of the code lock: link step, motion check, speaker step.
// Purely combinational; depends on cl_pkg.
module cl_core
    import cl_pkg::*;
#(
    parameter int TUNE_LENGTH = 16,
    parameter int IW = $clog2(TUNE_LENGTH + 1)
) (
    input  lock_state_t      st,
    input  logic [IW-1:0]    note_idx,
    input  lock_cfg_t        cfg,
    input  logic             serve_link,
    input  logic             rx_valid,
    input  logic [7:0]       rx_byte,
    input  logic             motion,
    output lock_state_t      st_next,
    output logic [IW-1:0]    note_idx_next,
    output logic [3:0]       note
);

    always_comb begin
        lock_state_t   s;
        logic [IW-1:0] idx;
        logic [3:0]    n;
        s   = st;
        idx = note_idx;
        n   = 4'd0;

        // link step
        if (serve_link) begin
            if (rx_valid) begin
                s.last_rx    = rx_byte;
                s.link_phase = s.link_phase + 2'd1;
            end
            case (s.link_phase)
                2'd1, 2'd2: begin
                    s.led = s.last_rx;
                    if (s.link_phase == 2'd1) begin
                        s.first_try = s.last_rx;
                    end else begin
                        s.second_try = s.last_rx;
                    end
                    if (s.last_rx == LOCK_CMD) begin
                        s.locked     = 1'b1;
                        s.sound_req  = SND_NONE;
                        s.link_phase = 2'd0;
                    end
                end
                2'd3: begin
                    if (s.first_try == cfg.code_one && s.second_try == cfg.code_two &&
                        s.last_rx == cfg.code_three) begin
                        s.locked     = 1'b0;
                        s.led        = 8'hFF;
                        s.sound_req  = SND_SUCCESS;
                        s.fail_count = 8'd0;
                    end else begin
                        s.locked     = 1'b1;
                        s.led        = s.last_rx;
                        s.fail_count = s.fail_count + 8'd1;
                        s.sound_req  = SND_FAIL;
                    end
                    if (s.fail_count == cfg.alarm_count) begin
                        s.sound_req = SND_ALARM;
                    end
                    s.link_phase = 2'd0;
                end
                default: begin
                    s.link_phase = 2'd0;
                    s.sound_req  = SND_NONE;
                end
            endcase
        end

        if (motion && s.locked) begin
            s.led       = 8'h01;
            s.sound_req = SND_ALARM;
        end

        // speaker step
        if (s.spk_mode == SND_NONE) begin
            if (s.sound_req >= SND_LOCK && s.sound_req <= SND_SUCCESS) begin
                s.spk_mode  = s.sound_req;
                s.sound_req = SND_NONE;
            end
        end else if (idx < IW'(TUNE_LENGTH)) begin
            // alarm loops while locked: restart in place of the last note
            if (s.spk_mode == SND_ALARM && idx == IW'(TUNE_LENGTH - 1) && s.locked) begin
                idx = '0;
            end
        end else begin
            idx        = '0;
            s.spk_mode = SND_NONE;
        end
        if (s.spk_mode == SND_NONE || s.spk_mode > SND_SUCCESS) begin
            s.spk_mode = SND_NONE;
        end else begin
            n   = tune_note(s.spk_mode, 4'(idx));
            idx = idx + IW'(1);
        end

        st_next       = s;
        note_idx_next = idx;
        note          = n;
    end

endmodule

FILE: hdl/code_lock_with_alarm_tunes.sv
// Channel   | Dir | Fields (tdata, low bit first)
// s_ item   | in  | serve_link[0] rx_valid[1] rx_byte[9:2] motion[10], 16 bits
// m_ item   | out | led_value[7:0] door_locked[8] tone_note[12:9] failed_tries[20:13], 24 bits
// APB cfg   | in  | code bytes one..three at 0x0/0x4/0x8, alarm count at 0xC
//
// One item per clock while m_tready keeps the output free; the result appears in the
// output register in the cycle after acceptance. The state update is a single
// combinational pass (cl_core) that stands between the accepted item and the state
// and result registers. s_tready drops only while a result is held and m_tready is low.
// Reset (aresetn low, synchronous) restores the lock state and config registers.
module code_lock_with_alarm_tunes
    import cl_pkg::*;
#(
    parameter int TUNE_LENGTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // serve_link, rx_valid, rx_byte[7:0], motion, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // led_value[7:0], door_locked, tone_note[3:0], failed_tries[7:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(TUNE_LENGTH + 1);

    lock_state_t   state_reg, state_next;
    logic [IW-1:0] note_idx_reg, note_idx_next;
    lock_cfg_t     cfg_reg;
    logic [3:0]    note;
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;
    logic          accept;
    logic          cfg_wr;
    logic [1:0]    reg_sel;

    assign pready   = 1'b1;
    assign reg_sel  = paddr[3:2];
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_one    <= 8'd1;
            cfg_reg.code_two    <= 8'd2;
            cfg_reg.code_three  <= 8'd3;
            cfg_reg.alarm_count <= 8'd3;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_CODE_ONE:   cfg_reg.code_one    <= pwdata[7:0];
                REG_CODE_TWO:   cfg_reg.code_two    <= pwdata[7:0];
                REG_CODE_THREE: cfg_reg.code_three  <= pwdata[7:0];
                REG_ALARM_CNT:  cfg_reg.alarm_count <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CODE_ONE:   prdata = {24'd0, cfg_reg.code_one};
            REG_CODE_TWO:   prdata = {24'd0, cfg_reg.code_two};
            REG_CODE_THREE: prdata = {24'd0, cfg_reg.code_three};
            REG_ALARM_CNT:  prdata = {24'd0, cfg_reg.alarm_count};
            default:        prdata = 32'd0;
        endcase
    end

    cl_core #(
        .TUNE_LENGTH(TUNE_LENGTH),
        .IW(IW)
    ) u_core (
        .st            (state_reg),
        .note_idx      (note_idx_reg),
        .cfg           (cfg_reg),
        .serve_link    (s_tdata[0]),
        .rx_valid      (s_tdata[1]),
        .rx_byte       (s_tdata[9:2]),
        .motion        (s_tdata[10]),
        .st_next       (state_next),
        .note_idx_next (note_idx_next),
        .note          (note)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.link_phase <= 2'd0;
            state_reg.last_rx    <= 8'd0;
            state_reg.first_try  <= 8'd0;
            state_reg.second_try <= 8'd0;
            state_reg.locked     <= 1'b1;
            state_reg.fail_count <= 8'd0;
            state_reg.sound_req  <= SND_LOCK;
            state_reg.spk_mode   <= SND_NONE;
            state_reg.led        <= 8'd0;
            note_idx_reg         <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                state_reg    <= state_next;
                note_idx_reg <= note_idx_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {3'd0, state_next.fail_count, note, state_next.locked,
                           state_next.led};
        end
    end

endmodule

FILE: hdl/cl_checker.sv
// Port-level checks for code_lock_with_alarm_tunes, bound to the top level.
// Depends only on the top level's ports.
module cl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // each accepted item shows a result on the next cycle
    a_item_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:9] <= 4'd8)
        else $error("tone_note out of range");

    // unlocking needs a match, which clears the failure count; any miss relocks
    a_unlock_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[20:13] == 8'd0)
        else $error("unlocked with failures counted");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind code_lock_with_alarm_tunes cl_checker u_cl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
